[rtl/swipe_pkg.sv]
// Shared types and constants for the swipe gesture recognizer.
// No dependencies; used by swipe_gesture_recognizer.
`default_nettype none

package swipe_pkg;

  localparam int COORD_BITS_DEF = 16;
  localparam int AMOUNT_BITS    = 17;
  localparam int THRESH_BITS    = 16;
  localparam int MASK_BITS      = 4;
  localparam int DIR_BITS       = 3;
  localparam int CFG_DATA_BITS  = 16;
  localparam int CFG_IDX_BITS   = 3;

  typedef enum logic [1:0] {
    OP_PRESS   = 2'd0,
    OP_MOVE    = 2'd1,
    OP_RELEASE = 2'd2,
    OP_END     = 2'd3
  } op_t;

  typedef enum logic [DIR_BITS-1:0] {
    DIR_NONE  = 3'd0,
    DIR_LEFT  = 3'd1,
    DIR_RIGHT = 3'd2,
    DIR_UP    = 3'd3,
    DIR_DOWN  = 3'd4
  } dir_t;

  // Direction bits inside allowed_mask / force_mask.
  localparam logic [MASK_BITS-1:0] MASK_LEFT  = 4'b0001;
  localparam logic [MASK_BITS-1:0] MASK_RIGHT = 4'b0010;
  localparam logic [MASK_BITS-1:0] MASK_UP    = 4'b0100;
  localparam logic [MASK_BITS-1:0] MASK_DOWN  = 4'b1000;

  // Configuration register indexes.
  localparam logic [CFG_IDX_BITS-1:0] REG_SWIPE_ENABLE = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_THRESHOLD_X  = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_THRESHOLD_Y  = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_ALLOWED_MASK = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] REG_FORCE_MASK   = 3'd4;

endpackage

`default_nettype wire

[rtl/swipe_gesture_recognizer.sv]
// Swipe gesture recognizer top level: event decode, classification, result register.
// Depends on swipe_pkg.
`default_nettype none

// Takes one pointer transaction (press, move, release, end gesture) per clock
// and returns exactly one result transaction for each. A press latches the
// start point and clears any gesture; a move measures dx/dy from the start
// point and, if no gesture is active and |dx| > threshold_x or
// |dy| > threshold_y, classifies it (horizontal only when |dx| > |dy|, so ties
// go vertical) and starts a gesture if the direction passes force_mask, or
// allowed_mask when force_mask is zero. While active, swipe_amount follows dx
// or dy. A release ends the gesture and lifts the pointer; end gesture clears
// the gesture even when the block is disabled. With swipe_enable low, press,
// move and release report accepted = 0 and change nothing. Throughput is one
// transaction per cycle unless the output is stalled: all decision logic
// sits between the gesture state registers and a single output register.
// in_stall rises only while it holds a result the consumer is stalling.
// Config writes are to be issued only while no transaction is in flight.
module swipe_gesture_recognizer #(
  parameter int COORD_BITS = swipe_pkg::COORD_BITS_DEF
) (
  input  wire                                     clk,
  input  wire                                     rst,
  // configuration write port
  input  wire                                     cfg_wr_en,
  input  wire [swipe_pkg::CFG_IDX_BITS-1:0]       cfg_index,
  input  wire [swipe_pkg::CFG_DATA_BITS-1:0]      cfg_wdata,
  // event channel
  input  wire                                     in_valid,
  output logic                                    in_stall,
  input  wire [1:0]                               op,
  input  wire signed [COORD_BITS-1:0]             pos_x,
  input  wire signed [COORD_BITS-1:0]             pos_y,
  // result channel
  output logic                                    out_valid,
  input  wire                                     out_stall,
  output logic                                    accepted,
  output logic                                    in_progress,
  output logic [swipe_pkg::DIR_BITS-1:0]          direction,
  output logic signed [swipe_pkg::AMOUNT_BITS-1:0] swipe_amount
);

  localparam int DW = COORD_BITS + 1;                         // delta width
  localparam int CW = (DW > swipe_pkg::THRESH_BITS) ? DW : swipe_pkg::THRESH_BITS;
  localparam int AW = (DW > swipe_pkg::AMOUNT_BITS) ? DW : swipe_pkg::AMOUNT_BITS;

  // ---------------- configuration registers ----------------
  logic                                  swipe_enable;
  logic [swipe_pkg::THRESH_BITS-1:0]     threshold_x;
  logic [swipe_pkg::THRESH_BITS-1:0]     threshold_y;
  logic [swipe_pkg::MASK_BITS-1:0]       allowed_mask;
  logic [swipe_pkg::MASK_BITS-1:0]       force_mask;

  always_ff @(posedge clk) begin
    if (rst) begin
      swipe_enable <= 1'b1;
      threshold_x  <= '0;
      threshold_y  <= '0;
      allowed_mask <= '1;
      force_mask   <= '0;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        swipe_pkg::REG_SWIPE_ENABLE: swipe_enable <= cfg_wdata[0];
        swipe_pkg::REG_THRESHOLD_X:  threshold_x  <= cfg_wdata[swipe_pkg::THRESH_BITS-1:0];
        swipe_pkg::REG_THRESHOLD_Y:  threshold_y  <= cfg_wdata[swipe_pkg::THRESH_BITS-1:0];
        swipe_pkg::REG_ALLOWED_MASK: allowed_mask <= cfg_wdata[swipe_pkg::MASK_BITS-1:0];
        swipe_pkg::REG_FORCE_MASK:   force_mask   <= cfg_wdata[swipe_pkg::MASK_BITS-1:0];
        default: ;                   // writes past the register list are dropped
      endcase
    end
  end

  // ---------------- gesture state ----------------
  logic signed [COORD_BITS-1:0]             start_x, start_x_next;
  logic signed [COORD_BITS-1:0]             start_y, start_y_next;
  logic                                     pointer_down, pointer_down_next;
  logic                                     gesture_active, gesture_active_next;
  swipe_pkg::dir_t                          current_direction, current_direction_next;
  logic signed [swipe_pkg::AMOUNT_BITS-1:0] current_amount, current_amount_next;
  logic                                     accepted_next;

  logic in_xfer;
  assign in_stall = out_valid & out_stall;
  assign in_xfer  = in_valid & ~in_stall;

  // displacement from the start point, one bit wider than a coordinate
  logic signed [DW-1:0] dx, dy;
  logic        [DW-1:0] abs_dx, abs_dy;
  logic                 exceed;
  swipe_pkg::dir_t      cls_dir;
  logic [swipe_pkg::MASK_BITS-1:0] cls_bit, eff_mask;
  logic                 dir_ok;
  logic signed [AW-1:0] dx_w, dy_w;

  assign dx = DW'(pos_x) - DW'(start_x);
  assign dy = DW'(pos_y) - DW'(start_y);
  assign abs_dx = dx[DW-1] ? (~dx + DW'(1)) : dx;
  assign abs_dy = dy[DW-1] ? (~dy + DW'(1)) : dy;

  assign exceed = (CW'(abs_dx) > CW'(threshold_x)) || (CW'(abs_dy) > CW'(threshold_y));

  always_comb begin
    if (abs_dx > abs_dy) begin
      if (!dx[DW-1] && (dx != '0)) begin
        cls_dir = swipe_pkg::DIR_RIGHT;
        cls_bit = swipe_pkg::MASK_RIGHT;
      end else begin
        cls_dir = swipe_pkg::DIR_LEFT;
        cls_bit = swipe_pkg::MASK_LEFT;
      end
    end else begin
      if (!dy[DW-1] && (dy != '0)) begin
        cls_dir = swipe_pkg::DIR_DOWN;
        cls_bit = swipe_pkg::MASK_DOWN;
      end else begin
        cls_dir = swipe_pkg::DIR_UP;
        cls_bit = swipe_pkg::MASK_UP;
      end
    end
  end

  assign eff_mask = (force_mask != '0) ? force_mask : allowed_mask;
  assign dir_ok   = (eff_mask & cls_bit) != '0;

  // sign-extend (or keep) the delta, then wrap to the amount width
  assign dx_w = AW'(dx);
  assign dy_w = AW'(dy);

  always_comb begin
    start_x_next           = start_x;
    start_y_next           = start_y;
    pointer_down_next      = pointer_down;
    gesture_active_next    = gesture_active;
    current_direction_next = current_direction;
    current_amount_next    = current_amount;
    accepted_next          = 1'b0;

    unique case (swipe_pkg::op_t'(op))
      swipe_pkg::OP_PRESS: begin
        if (swipe_enable) begin
          start_x_next           = pos_x;
          start_y_next           = pos_y;
          pointer_down_next      = 1'b1;
          gesture_active_next    = 1'b0;
          current_direction_next = swipe_pkg::DIR_NONE;
          current_amount_next    = '0;
          accepted_next          = 1'b1;
        end
      end
      swipe_pkg::OP_MOVE: begin
        if (swipe_enable && pointer_down) begin
          if (!gesture_active && exceed && dir_ok) begin
            gesture_active_next    = 1'b1;
            current_direction_next = cls_dir;
          end
          if (gesture_active_next) begin
            if ((current_direction_next == swipe_pkg::DIR_LEFT) ||
                (current_direction_next == swipe_pkg::DIR_RIGHT)) begin
              current_amount_next = dx_w[swipe_pkg::AMOUNT_BITS-1:0];
            end else begin
              current_amount_next = dy_w[swipe_pkg::AMOUNT_BITS-1:0];
            end
          end
          accepted_next = 1'b1;
        end
      end
      swipe_pkg::OP_RELEASE: begin
        if (swipe_enable) begin
          pointer_down_next      = 1'b0;
          gesture_active_next    = 1'b0;
          current_direction_next = swipe_pkg::DIR_NONE;
          current_amount_next    = '0;
          accepted_next          = 1'b1;
        end
      end
      swipe_pkg::OP_END: begin
        // clears the gesture even when disabled; pointer stays down
        gesture_active_next    = 1'b0;
        current_direction_next = swipe_pkg::DIR_NONE;
        current_amount_next    = '0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      start_x           <= '0;
      start_y           <= '0;
      pointer_down      <= 1'b0;
      gesture_active    <= 1'b0;
      current_direction <= swipe_pkg::DIR_NONE;
      current_amount    <= '0;
    end else if (in_xfer) begin
      start_x           <= start_x_next;
      start_y           <= start_y_next;
      pointer_down      <= pointer_down_next;
      gesture_active    <= gesture_active_next;
      current_direction <= current_direction_next;
      current_amount    <= current_amount_next;
    end
  end

  // ---------------- result register ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_xfer) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // payload loads only on a new transaction, so it holds while stalled
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      accepted     <= accepted_next;
      in_progress  <= gesture_active_next;
      direction    <= current_direction_next;
      swipe_amount <= current_amount_next;
    end
  end

  // ---------------- assertions ----------------
  // an active gesture needs the pointer down
  a_active_needs_pointer: assert property (@(posedge clk) disable iff (rst)
    gesture_active |-> pointer_down)
    else $error("gesture active with pointer up");

  // no gesture means no direction and no amount
  a_idle_state_clear: assert property (@(posedge clk) disable iff (rst)
    !gesture_active |-> (current_direction == swipe_pkg::DIR_NONE) && (current_amount == '0))
    else $error("stale direction or amount without gesture");

  // an active gesture always carries a direction
  a_active_has_dir: assert property (@(posedge clk) disable iff (rst)
    gesture_active |-> (current_direction != swipe_pkg::DIR_NONE))
    else $error("gesture active without direction");

  // reported result matches the state it was taken from
  a_result_tracks_state: assert property (@(posedge clk) disable iff (rst)
    in_xfer |=> (in_progress == gesture_active) && (direction == current_direction) &&
                (swipe_amount == current_amount))
    else $error("result register out of step with gesture state");

endmodule

`default_nettype wire

[verif/tb_swipe_gesture_recognizer.sv]
// Self-checking testbench for swipe_gesture_recognizer: directed and random pointer traffic.
// Depends on swipe_pkg and the swipe_gesture_recognizer RTL; nothing else.
`timescale 1ns / 100ps

module tb_swipe_gesture_recognizer;
  import swipe_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;  // cycles with no transaction on either channel

  // One result transaction as the block reports it.
  typedef struct {
    logic               accepted;
    logic               in_progress;
    logic [2:0]         direction;
    logic signed [16:0] amount;
  } gesture_report_t;

  // ---------------------------------------------------------------------------
  // DUT signals; every input has a known value from time zero
  // ---------------------------------------------------------------------------
  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     cfg_wr_en = 1'b0;
  logic [CFG_IDX_BITS-1:0]  cfg_index = '0;
  logic [CFG_DATA_BITS-1:0] cfg_wdata = '0;
  logic                     in_valid = 1'b0;
  logic                     in_stall;
  logic [1:0]               op = OP_END;
  logic signed [15:0]       pos_x = '0;
  logic signed [15:0]       pos_y = '0;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  logic                     accepted;
  logic                     in_progress;
  logic [DIR_BITS-1:0]      direction;
  logic signed [AMOUNT_BITS-1:0] swipe_amount;

  swipe_gesture_recognizer #(.COORD_BITS(16)) dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .op           (op),
    .pos_x        (pos_x),
    .pos_y        (pos_y),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .accepted     (accepted),
    .in_progress  (in_progress),
    .direction    (direction),
    .swipe_amount (swipe_amount)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Gesture predictor: own copy of registers and state, reset values here
  // ---------------------------------------------------------------------------
  logic               sw_enable  = 1'b1;
  logic [15:0]        sw_thr_x   = '0;
  logic [15:0]        sw_thr_y   = '0;
  logic [3:0]         sw_allowed = 4'hF;
  logic [3:0]         sw_force   = 4'h0;
  logic signed [15:0] sw_start_x = '0;
  logic signed [15:0] sw_start_y = '0;
  logic               sw_down    = 1'b0;
  logic               sw_active  = 1'b0;
  dir_t               sw_dir     = DIR_NONE;
  logic signed [16:0] sw_amount  = '0;

  gesture_report_t pending_reports[$];  // results still owed by the block, oldest first
  int fail_count      = 0;
  int events_consumed = 0;  // transactions the block should report as accepted
  int events_sent     = 0;
  bit in_gaps         = 1'b1;
  bit out_gaps        = 1'b1;
  int stall_left      = 0;
  int quiet_cycles    = 0;

  function automatic int abs_px(int v);
    return (v < 0) ? -v : v;
  endfunction

  function automatic void drop_gesture();
    sw_active = 1'b0;
    sw_dir    = DIR_NONE;
    sw_amount = '0;
  endfunction

  // Advance the predicted state by one event and return what the block reports.
  function automatic gesture_report_t step_gesture(op_t kind, logic signed [15:0] x,
                                                   logic signed [15:0] y);
    gesture_report_t r;
    int dx, dy;
    dir_t d;
    logic [3:0] dbit, gate;
    r.accepted = 1'b0;
    case (kind)
      OP_PRESS: begin
        if (sw_enable) begin
          sw_start_x = x;
          sw_start_y = y;
          sw_down    = 1'b1;
          drop_gesture();
          r.accepted = 1'b1;
        end
      end
      OP_MOVE: begin
        if (sw_enable && sw_down) begin
          dx = int'(x) - int'(sw_start_x);
          dy = int'(y) - int'(sw_start_y);
          if (!sw_active && (abs_px(dx) > int'(sw_thr_x) || abs_px(dy) > int'(sw_thr_y))) begin
            // horizontal only on a strict win, so ties go vertical
            if (abs_px(dx) > abs_px(dy)) d = (dx > 0) ? DIR_RIGHT : DIR_LEFT;
            else d = (dy > 0) ? DIR_DOWN : DIR_UP;
            case (d)
              DIR_LEFT:  dbit = MASK_LEFT;
              DIR_RIGHT: dbit = MASK_RIGHT;
              DIR_UP:    dbit = MASK_UP;
              default:   dbit = MASK_DOWN;
            endcase
            gate = (sw_force != 4'h0) ? sw_force : sw_allowed;
            if ((gate & dbit) != 4'h0) begin
              sw_dir    = d;
              sw_active = 1'b1;
            end
          end
          if (sw_active) begin
            sw_amount = (sw_dir == DIR_LEFT || sw_dir == DIR_RIGHT) ? 17'(dx) : 17'(dy);
          end
          r.accepted = 1'b1;
        end
      end
      OP_RELEASE: begin
        if (sw_enable) begin
          drop_gesture();
          sw_down    = 1'b0;
          r.accepted = 1'b1;
        end
      end
      default: drop_gesture();  // end gesture works even when disabled, pointer stays down
    endcase
    r.in_progress = sw_active;
    r.direction   = sw_dir;
    r.amount      = sw_amount;
    return r;
  endfunction

  // Length of an idle burst: none most of the time, else a random nonzero length.
  function automatic int idle_burst(int one_in);
    return ($urandom_range(1, one_in) == 1) ? $urandom_range(1, 19) : 0;
  endfunction

  // ---------------------------------------------------------------------------
  // Event channel driver
  // ---------------------------------------------------------------------------
  // Drives at the falling edge, waits for the accepting rising edge, then
  // predicts. Valid stays high after acceptance; the next call or a drain
  // decides whether it drops, so it never toggles twice in one step.
  task automatic send_event(op_t kind, logic signed [15:0] x, logic signed [15:0] y);
    int gap;
    gesture_report_t r;
    gap = in_gaps ? idle_burst(4) : 0;
    @(negedge clk);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    op       <= kind;
    pos_x    <= x;
    pos_y    <= y;
    do @(posedge clk); while (in_stall);
    r = step_gesture(kind, x, y);
    pending_reports.push_back(r);
    events_sent++;
    if (r.accepted) events_consumed++;
  endtask

  // Stop sending and wait until every owed result has come back and the
  // result register has settled, so the block is idle.
  task automatic drain_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] data);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    case (idx)
      REG_SWIPE_ENABLE: sw_enable  = data[0];
      REG_THRESHOLD_X:  sw_thr_x   = data;
      REG_THRESHOLD_Y:  sw_thr_y   = data;
      REG_ALLOWED_MASK: sw_allowed = data[3:0];
      REG_FORCE_MASK:   sw_force   = data[3:0];
      default: ;
    endcase
  endtask

  // Block must be idle: callers drain first.
  task automatic apply_config(logic en, logic [15:0] thx, logic [15:0] thy,
                              logic [3:0] allowed_bits, logic [3:0] force_bits);
    write_reg(REG_SWIPE_ENABLE, {15'd0, en});
    write_reg(REG_THRESHOLD_X, thx);
    write_reg(REG_THRESHOLD_Y, thy);
    write_reg(REG_ALLOWED_MASK, {12'd0, allowed_bits});
    write_reg(REG_FORCE_MASK, {12'd0, force_bits});
  endtask

  // ---------------------------------------------------------------------------
  // Result channel: random stall bursts, then compare with the oldest prediction
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (!out_gaps) begin
      stall_left = 0;
      out_stall <= 1'b0;
    end else begin
      if (stall_left == 0) stall_left = idle_burst(8);
      out_stall <= (stall_left != 0);
      if (stall_left != 0) stall_left--;
    end
  end

  task automatic report_mismatch(string field, logic signed [31:0] want,
                                 logic signed [31:0] got);
    $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
    fail_count++;
  endtask

  always @(posedge clk) begin
    gesture_report_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_reports.size() == 0) begin
        $display("%0t: result transaction with none expected, actual %0d/%0d/%0d/%0d",
                 $time, accepted, in_progress, direction, swipe_amount);
        fail_count++;
      end else begin
        want = pending_reports.pop_front();
        if (accepted !== want.accepted)
          report_mismatch("accepted", want.accepted, accepted);
        if (in_progress !== want.in_progress)
          report_mismatch("in_progress", want.in_progress, in_progress);
        if (direction !== want.direction)
          report_mismatch("direction", want.direction, direction);
        if (swipe_amount !== want.amount)
          report_mismatch("swipe_amount", want.amount, swipe_amount);
      end
    end
  end

  // Watchdog: a hang shows up as a long run of cycles with no transaction.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Directed tests
  // ---------------------------------------------------------------------------
  // Reset register values: enabled, zero thresholds, all directions allowed.
  task automatic test_defaults();
    send_event(OP_MOVE, 16'sd5, 16'sd5);     // move with no press: ignored
    send_event(OP_PRESS, 16'sd0, 16'sd0);
    send_event(OP_MOVE, 16'sd1, 16'sd0);     // right, amount 1
    send_event(OP_MOVE, -16'sd5, 16'sd3);    // gesture stays right, amount follows dx
    send_event(OP_RELEASE, 16'sd0, 16'sd0);
    send_event(OP_END, 16'sd0, 16'sd0);
    send_event(OP_MOVE, 16'sd3, 16'sd3);     // pointer is up: ignored
    drain_results();
  endtask

  task automatic test_classify();
    send_event(OP_PRESS, 16'sd100, 16'sd100);
    send_event(OP_MOVE, 16'sd100, 16'sd100); // zero displacement never classifies
    send_event(OP_MOVE, 16'sd99, 16'sd100);  // left
    send_event(OP_PRESS, 16'sd0, 16'sd0);
    send_event(OP_MOVE, -16'sd4, 16'sd4);    // tie goes vertical: down
    send_event(OP_PRESS, 16'sd0, 16'sd0);
    send_event(OP_MOVE, 16'sd0, -16'sd2);    // up
    drain_results();
  endtask

  // Full-range coordinates give the widest swipe amounts both ways.
  task automatic test_extremes();
    send_event(OP_PRESS, -16'sd32768, -16'sd32768);
    send_event(OP_MOVE, 16'sd32767, 16'sd32767);
    send_event(OP_PRESS, 16'sd32767, 16'sd0);
    send_event(OP_MOVE, -16'sd32768, 16'sd0);
    drain_results();
  endtask

  task automatic test_masks();
    apply_config(1'b1, 16'd0, 16'd0, MASK_UP, 4'h0);
    send_event(OP_PRESS, 16'sd0, 16'sd0);
    send_event(OP_MOVE, 16'sd5, 16'sd0);     // right not allowed
    send_event(OP_MOVE, 16'sd0, -16'sd5);    // retried while idle: up passes
    drain_results();
    write_reg(REG_FORCE_MASK, {12'd0, MASK_LEFT});  // force overrides allowed
    send_event(OP_PRESS, 16'sd0, 16'sd0);
    send_event(OP_MOVE, 16'sd0, -16'sd5);
    send_event(OP_MOVE, -16'sd5, 16'sd0);
    drain_results();
  endtask

  // Disabled block ignores pointer events but end gesture still clears.
  task automatic test_disabled();
    apply_config(1'b1, 16'd0, 16'd0, 4'hF, 4'h0);
    send_event(OP_PRESS, 16'sd0, 16'sd0);
    send_event(OP_MOVE, 16'sd0, 16'sd9);
    drain_results();
    write_reg(REG_SWIPE_ENABLE, 16'd0);
    send_event(OP_PRESS, 16'sd1, 16'sd1);
    send_event(OP_MOVE, 16'sd2, 16'sd2);
    send_event(OP_RELEASE, 16'sd0, 16'sd0);
    send_event(OP_END, 16'sd0, 16'sd0);
    drain_results();
    write_reg(REG_SWIPE_ENABLE, 16'd1);
    send_event(OP_MOVE, 16'sd3, 16'sd0);     // pointer still down from before
    drain_results();
  endtask

  // ---------------------------------------------------------------------------
  // Random traffic
  // ---------------------------------------------------------------------------
  // Mostly small thresholds so gestures trigger; sometimes the full range.
  function automatic logic [15:0] pick_threshold();
    return ($urandom_range(0, 7) == 0) ? 16'($urandom) : 16'($urandom_range(0, 40));
  endfunction

  // Offset from the start point, clustered around the threshold.
  function automatic logic signed [15:0] rand_offset(logic [15:0] thr);
    int span, mag;
    if ($urandom_range(0, 7) == 0) return 16'($urandom);
    span = int'(thr) * 2 + 2;
    if (span > 65535) span = 65535;
    mag = $urandom_range(0, span);
    return 16'(($urandom_range(0, 1) != 0) ? -mag : mag);
  endfunction

  task automatic send_moves(logic signed [15:0] sx, logic signed [15:0] sy, int count);
    logic signed [15:0] ox, oy;
    repeat (count) begin
      ox = rand_offset(sw_thr_x);
      oy = rand_offset(sw_thr_y);
      if ($urandom_range(0, 9) == 0) oy = ($urandom_range(0, 1) != 0) ? ox : -ox;  // ties
      send_event(OP_MOVE, sx + ox, sy + oy);
    end
  endtask

  // Press / moves / release sequences with some noise. Stops after target consumed
  // transactions, or after twice target sent, which ends disabled phases.
  task automatic run_gesture_traffic(int target);
    int consumed_base, sent_base;
    logic signed [15:0] sx, sy;
    consumed_base = events_consumed;
    sent_base     = events_sent;
    while (events_consumed - consumed_base < target && events_sent - sent_base < 2 * target) begin
      if ($urandom_range(0, 9) == 0) begin
        send_event(op_t'($urandom_range(0, 3)), 16'($urandom), 16'($urandom));
      end else begin
        sx = 16'($urandom);
        sy = 16'($urandom);
        send_event(OP_PRESS, sx, sy);
        send_moves(sx, sy, $urandom_range(1, 8));
        case ($urandom_range(0, 3))
          0, 1: send_event(OP_RELEASE, 16'($urandom), 16'($urandom));
          2: begin
            send_event(OP_END, 16'($urandom), 16'($urandom));
            send_moves(sx, sy, $urandom_range(1, 3));
          end
          default: ;  // pointer left down, next press restarts
        endcase
      end
    end
  endtask

  task automatic test_random();
    for (int phase = 0; phase < 16; phase++) begin
      drain_results();  // also the pause until every result is back
      if (phase >= 14) begin
        in_gaps  = 1'b0;
        out_gaps = 1'b0;
      end else begin
        in_gaps  = ($urandom_range(0, 3) != 0);
        out_gaps = ($urandom_range(0, 3) != 0);
      end
      case (phase)
        0: apply_config(1'b1, 16'd0, 16'd0, 4'hF, 4'h0);
        1: apply_config(1'b1, 16'hFFFF, 16'hFFFF, 4'hF, 4'h0);
        2: apply_config(1'b1, 16'd3, 16'd3, 4'h0, 4'h0);
        3: apply_config(1'b1, 16'd2, 16'd5, 4'h0, 4'hF);
        4: apply_config(1'b0, pick_threshold(), pick_threshold(), 4'hF, 4'h0);
        default: apply_config($urandom_range(0, 9) != 0, pick_threshold(), pick_threshold(),
                              4'($urandom_range(0, 15)),
                              ($urandom_range(0, 1) != 0) ? 4'($urandom_range(1, 15)) : 4'h0);
      endcase
      run_gesture_traffic(sw_enable ? 125 : 20);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Sequence: reset once, directed tests, random traffic, final check
  // ---------------------------------------------------------------------------
  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_defaults();
    test_classify();
    test_extremes();
    test_masks();
    test_disabled();
    test_random();
    drain_results();
    repeat (5) @(posedge clk);
    if (fail_count == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule

[swipe_gesture_recognizer.f]
rtl/swipe_pkg.sv
rtl/swipe_gesture_recognizer.sv
verif/tb_swipe_gesture_recognizer.sv
